FILE: hw/rtl/quaternion_normalizer_macros.svh
// Assertion helpers shared by the normalizer RTL.
`ifndef QUATERNION_NORMALIZER_MACROS_SVH
`define QUATERNION_NORMALIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define QN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qn assertion failed");

// Next-cycle implication, checked out of reset.
`define QN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qn assertion failed");

`endif

FILE: hw/rtl/qn_pkg.sv
package qn_pkg;

  localparam int CompBits    = 16;
  localparam int FracBits    = 14;
  localparam int NumComps    = 4;
  localparam int FrontStages = 4;
  localparam int SqBits      = 2 * CompBits + 1;
  localparam int RootBits    = CompBits + 1;
  localparam int RadBits     = 2 * RootBits;
  localparam int RemBits     = RootBits + 2;
  localparam int QuoBits     = FracBits + 1;
  localparam int DivRemBits  = RootBits + 1;
  localparam int DvdBits     = CompBits + FracBits;
  localparam int HiBits      = DvdBits - QuoBits;

  // Item state inside the square-root cells.
  typedef struct packed {
    logic [RadBits-1:0]                   rad;
    logic [RemBits-1:0]                   rem;
    logic [RootBits-1:0]                  root;
    logic [NumComps-1:0][CompBits-1:0]    mag;
    logic [NumComps-1:0]                  neg;
    logic [SqBits-1:0]                    sumsq;
    logic                                 zero;
  } sq_t;

  // Item state inside the divider cells, four lanes sharing one divisor.
  typedef struct packed {
    logic [NumComps-1:0][DivRemBits-1:0]  rem;
    logic [NumComps-1:0][QuoBits-1:0]     low;
    logic [NumComps-1:0][QuoBits-1:0]     quo;
    logic [RootBits-1:0]                  len;
    logic [NumComps-1:0]                  neg;
    logic [SqBits-1:0]                    sumsq;
    logic                                 zero;
  } dv_t;

endpackage

FILE: hw/rtl/qn_sqrt_cell.sv
module qn_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  qn_pkg::sq_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output qn_pkg::sq_t  out_data
);

  logic                         valid_r;
  qn_pkg::sq_t                  data_r;
  qn_pkg::sq_t                  data_nxt;
  logic [qn_pkg::RemBits-1:0]   rem_sh;
  logic [qn_pkg::RemBits-1:0]   trial;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // one root bit per cell: bring down two radicand bits, try (4*root + 1)
  always_comb begin
    data_nxt     = in_data;
    rem_sh       = {in_data.rem[qn_pkg::RemBits-3:0], in_data.rad[qn_pkg::RadBits-1 -: 2]};
    trial        = {in_data.root, 2'b01};
    data_nxt.rad = {in_data.rad[qn_pkg::RadBits-3:0], 2'b00};
    if (rem_sh >= trial) begin
      data_nxt.rem  = rem_sh - trial;
      data_nxt.root = {in_data.root[qn_pkg::RootBits-2:0], 1'b1};
    end else begin
      data_nxt.rem  = rem_sh;
      data_nxt.root = {in_data.root[qn_pkg::RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hw/rtl/qn_div_cell.sv
module qn_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  qn_pkg::dv_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output qn_pkg::dv_t  out_data
);

  logic                                               valid_r;
  qn_pkg::dv_t                                        data_r;
  qn_pkg::dv_t                                        data_nxt;
  logic [qn_pkg::NumComps-1:0][qn_pkg::DivRemBits-1:0] rem_sh;
  logic [qn_pkg::DivRemBits-1:0]                      dvsr;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // one quotient bit per cell in each of the four lanes
  always_comb begin
    data_nxt = in_data;
    dvsr     = {1'b0, in_data.len};
    for (int i = 0; i < qn_pkg::NumComps; i++) begin
      rem_sh[i] = {in_data.rem[i][qn_pkg::DivRemBits-2:0],
                   in_data.low[i][qn_pkg::QuoBits-1]};
      data_nxt.low[i] = {in_data.low[i][qn_pkg::QuoBits-2:0], 1'b0};
      if (rem_sh[i] >= dvsr) begin
        data_nxt.rem[i] = rem_sh[i] - dvsr;
        data_nxt.quo[i] = {in_data.quo[i][qn_pkg::QuoBits-2:0], 1'b1};
      end else begin
        data_nxt.rem[i] = rem_sh[i];
        data_nxt.quo[i] = {in_data.quo[i][qn_pkg::QuoBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hw/rtl/quaternion_normalizer.sv
// Channel | Ports             | Payload
// in      | in_t{valid,ready} | in_tdata: comp_x, comp_y, comp_z, comp_w (16 b each)
// out     | out_t{valid,ready}| out_tdata: length_squared, length, unit_x..w; tuser: zero_length
//
// Pipeline: 4 front stages (magnitude, square, pair sum, total), 17 square-root
// cells, 15 divider cells and the output register. One item per cycle sustained
// while the output does not stall; every stage is a register, one root or quotient
// bit per cell. Ready ripples back stage by stage, so bubbles close up during
// a stall on the output. rst_n (synchronous) clears the valid bits only.
`include "quaternion_normalizer_macros.svh"

module quaternion_normalizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // comp_x, comp_y, comp_z, comp_w
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // length_squared, length, unit_x, unit_y, unit_z, unit_w, pad
  output logic [0:0]   out_tuser   // zero_length
);

  typedef struct packed {
    logic [qn_pkg::NumComps-1:0][qn_pkg::CompBits-1:0] mag;
    logic [qn_pkg::NumComps-1:0]                       neg;
    logic                                              zero;
  } side_t;

  // front stages
  logic [qn_pkg::FrontStages-1:0]                       fv_r;
  logic [qn_pkg::FrontStages:0]                         f_rdy;
  side_t [qn_pkg::FrontStages-1:0]                      side_r;
  side_t                                                side_nxt;
  logic [qn_pkg::NumComps-1:0][2*qn_pkg::CompBits-1:0]  sqr_r;
  logic [1:0][qn_pkg::SqBits-1:0]                       pair_r;
  logic [qn_pkg::SqBits-1:0]                            sum_r;
  logic [qn_pkg::CompBits-1:0]                          raw;

  // cell chains
  logic [qn_pkg::RootBits:0]  sq_v;
  logic [qn_pkg::RootBits:0]  sq_rdy;
  qn_pkg::sq_t                sq_d [qn_pkg::RootBits+1];
  logic [qn_pkg::QuoBits:0]   dv_v;
  logic [qn_pkg::QuoBits:0]   dv_rdy;
  qn_pkg::dv_t                dv_d [qn_pkg::QuoBits+1];
  logic [qn_pkg::NumComps-1:0][qn_pkg::DvdBits-1:0] dvd;

  // output stage
  logic                                               out_rdy;
  logic                                               out_valid_r;
  logic [qn_pkg::SqBits-1:0]                          lsq_r;
  logic [qn_pkg::RootBits-1:0]                        len_r;
  logic [qn_pkg::NumComps-1:0][qn_pkg::CompBits-1:0]  unit_r;
  logic [qn_pkg::NumComps-1:0][qn_pkg::CompBits-1:0]  unit_nxt;
  logic                                               zero_r;
  logic [qn_pkg::QuoBits-1:0]                         qc;
  logic [qn_pkg::CompBits-1:0]                        qx;
  logic [qn_pkg::QuoBits-1:0]                         one_q;

  assign in_tready = f_rdy[0];
  // walk from the sqrt side back toward the input
  always_comb begin
    f_rdy[qn_pkg::FrontStages] = sq_rdy[0];
    for (int k = qn_pkg::FrontStages - 1; k >= 0; k--) begin
      f_rdy[k] = !fv_r[k] || f_rdy[k+1];
    end
  end

  always_comb begin
    side_nxt.zero = 1'b1;
    for (int i = 0; i < qn_pkg::NumComps; i++) begin
      raw              = in_tdata[i*qn_pkg::CompBits +: qn_pkg::CompBits];
      side_nxt.neg[i]  = raw[qn_pkg::CompBits-1];
      side_nxt.mag[i]  = raw[qn_pkg::CompBits-1] ? (~raw + 1'b1) : raw;
      if (raw != '0) begin
        side_nxt.zero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      if (f_rdy[0]) fv_r[0] <= in_tvalid;
      for (int k = 1; k < qn_pkg::FrontStages; k++) begin
        if (f_rdy[k]) fv_r[k] <= fv_r[k-1];
      end
    end
    if (f_rdy[0] && in_tvalid) begin
      side_r[0] <= side_nxt;
    end
    if (f_rdy[1] && fv_r[0]) begin
      side_r[1] <= side_r[0];
      for (int i = 0; i < qn_pkg::NumComps; i++) begin
        sqr_r[i] <= side_r[0].mag[i] * side_r[0].mag[i];
      end
    end
    if (f_rdy[2] && fv_r[1]) begin
      side_r[2] <= side_r[1];
      pair_r[0] <= {1'b0, sqr_r[0]} + {1'b0, sqr_r[1]};
      pair_r[1] <= {1'b0, sqr_r[2]} + {1'b0, sqr_r[3]};
    end
    if (f_rdy[3] && fv_r[2]) begin
      side_r[3] <= side_r[2];
      sum_r     <= pair_r[0] + pair_r[1];
    end
  end

  // square root: one cell per root bit
  assign sq_v[0] = fv_r[qn_pkg::FrontStages-1];
  always_comb begin
    sq_d[0]       = '0;
    sq_d[0].rad   = {{(qn_pkg::RadBits-qn_pkg::SqBits){1'b0}}, sum_r};
    sq_d[0].mag   = side_r[qn_pkg::FrontStages-1].mag;
    sq_d[0].neg   = side_r[qn_pkg::FrontStages-1].neg;
    sq_d[0].zero  = side_r[qn_pkg::FrontStages-1].zero;
    sq_d[0].sumsq = sum_r;
  end

  for (genvar g = 0; g < qn_pkg::RootBits; g++) begin : g_sqrt
    qn_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[g]),
      .in_ready  (sq_rdy[g]),
      .in_data   (sq_d[g]),
      .out_valid (sq_v[g+1]),
      .out_ready (sq_rdy[g+1]),
      .out_data  (sq_d[g+1])
    );
  end

  // hand over to the divider: dividend is mag << FracBits, its top part seeds the remainder
  assign dv_v[0]                 = sq_v[qn_pkg::RootBits];
  assign sq_rdy[qn_pkg::RootBits] = dv_rdy[0];
  always_comb begin
    dv_d[0]       = '0;
    dv_d[0].len   = sq_d[qn_pkg::RootBits].root;
    dv_d[0].neg   = sq_d[qn_pkg::RootBits].neg;
    dv_d[0].zero  = sq_d[qn_pkg::RootBits].zero;
    dv_d[0].sumsq = sq_d[qn_pkg::RootBits].sumsq;
    for (int i = 0; i < qn_pkg::NumComps; i++) begin
      dvd[i]         = {sq_d[qn_pkg::RootBits].mag[i], {qn_pkg::FracBits{1'b0}}};
      dv_d[0].rem[i] = {{(qn_pkg::DivRemBits-qn_pkg::HiBits){1'b0}},
                        dvd[i][qn_pkg::DvdBits-1:qn_pkg::QuoBits]};
      dv_d[0].low[i] = dvd[i][qn_pkg::QuoBits-1:0];
    end
  end

  for (genvar g = 0; g < qn_pkg::QuoBits; g++) begin : g_div
    qn_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[g]),
      .in_ready  (dv_rdy[g]),
      .in_data   (dv_d[g]),
      .out_valid (dv_v[g+1]),
      .out_ready (dv_rdy[g+1]),
      .out_data  (dv_d[g+1])
    );
  end

  // clamp to 1.0, zero when length is zero, restore sign
  assign one_q                   = {1'b1, {qn_pkg::FracBits{1'b0}}};
  assign out_rdy                 = !out_valid_r || out_tready;
  assign dv_rdy[qn_pkg::QuoBits] = out_rdy;
  always_comb begin
    for (int i = 0; i < qn_pkg::NumComps; i++) begin
      if (dv_d[qn_pkg::QuoBits].zero || dv_d[qn_pkg::QuoBits].len == '0) begin
        qc = '0;
      end else if (dv_d[qn_pkg::QuoBits].quo[i] > one_q) begin
        qc = one_q;
      end else begin
        qc = dv_d[qn_pkg::QuoBits].quo[i];
      end
      qx          = {{(qn_pkg::CompBits-qn_pkg::QuoBits){1'b0}}, qc};
      unit_nxt[i] = dv_d[qn_pkg::QuoBits].neg[i] ? (~qx + 1'b1) : qx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= dv_v[qn_pkg::QuoBits];
    end
    if (out_rdy && dv_v[qn_pkg::QuoBits]) begin
      lsq_r  <= dv_d[qn_pkg::QuoBits].sumsq;
      len_r  <= dv_d[qn_pkg::QuoBits].len;
      unit_r <= unit_nxt;
      zero_r <= dv_d[qn_pkg::QuoBits].zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, unit_r, len_r, lsq_r};
  assign out_tuser  = zero_r;

  `QN_ASSERT_NOW(a_zero_sum, out_valid_r && zero_r, lsq_r == '0 && len_r == '0)
  `QN_ASSERT_NOW(a_zero_units, out_valid_r && zero_r, unit_r == '0)
  `QN_ASSERT_NOW(a_root_low, out_valid_r && !zero_r, ({1'b0, len_r} * {1'b0, len_r}) <= {3'b0, lsq_r})
  `QN_ASSERT_NEXT(a_front_hold, fv_r[qn_pkg::FrontStages-1] && !f_rdy[qn_pkg::FrontStages], fv_r[qn_pkg::FrontStages-1])
  `QN_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready, out_valid_r && $stable(unit_r))

endmodule
